/* src/msf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msf_pkg: markup strip filter package
// transaction types, character codes and the single-byte decision function
// ----------------------------------------------------------------------------
package msf_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_AMP   = 8'h26;  // '&'
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;  // ';'
   localparam logic [7:0] CHAR_LBR   = 8'h7B;  // '{'
   localparam logic [7:0] CHAR_RBR   = 8'h7D;  // '}'
   localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] kept_byte;
      logic       byte_valid;
      logic       end_of_text;
      logic       last_of_item;
   } rsp_type;

   typedef struct packed {
      logic tag;
      logic cloze;
      logic entity;
   } flags_type;

   typedef struct packed {
      flags_type flags;
      logic      keep;
   } single_type;

   // byte with no pair partner
   function automatic single_type treat_single(flags_type f, logic [7:0] c);
      single_type r;
      r.flags = f;
      r.keep  = 1'b0;
      case (c)
         CHAR_LT:   r.flags.tag    = 1'b1;
         CHAR_GT:   r.flags.tag    = 1'b0;
         CHAR_AMP:  r.flags.entity = 1'b1;
         CHAR_SEMI: r.flags.entity = 1'b0;
         default:   r.keep = !(f.tag || f.cloze || f.entity);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/msf_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msf_step: filter state and per-byte decision
// holds the markup flags and the pair candidate byte, and turns one request
// transaction into up to two response transactions
// ----------------------------------------------------------------------------
module msf_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire msf_pkg::req_type req,
   output msf_pkg::rsp_type      rsp0,
   output msf_pkg::rsp_type      rsp1,
   output logic [1:0]            push_count
);
   import msf_pkg::*;

   flags_type  flags_ff, flags_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       held_valid_ff, held_valid_in;

   logic       pair_open, pair_close, pair_brace, paired;
   single_type held_res, fresh_res;
   flags_type  mid_flags;
   logic       keep_held, keep_fresh, candidate, hold;
   logic [7:0] c;
   logic       last;

   assign c    = req.text_byte;
   assign last = req.final_byte;

   assign pair_open  = held_valid_ff && held_char_ff == CHAR_LBR && c == CHAR_LBR;
   assign pair_close = held_valid_ff && held_char_ff == CHAR_COLON && c == CHAR_COLON
                       && flags_ff.cloze;
   assign pair_brace = held_valid_ff && held_char_ff == CHAR_RBR && c == CHAR_RBR;
   assign paired     = pair_open || pair_close || pair_brace;

   always_comb begin
      held_res  = treat_single(flags_ff, held_char_ff);
      keep_held = held_valid_ff && !paired && held_res.keep;
      mid_flags = (held_valid_ff && !paired) ? held_res.flags : flags_ff;
      candidate = c == CHAR_LBR || c == CHAR_RBR || (c == CHAR_COLON && mid_flags.cloze);
      hold      = !paired && candidate && !last;
      fresh_res = treat_single(mid_flags, c);
      keep_fresh = !paired && !hold && fresh_res.keep;
   end

   // next state
   always_comb begin
      flags_in      = flags_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      if (accept) begin
         if (paired) begin
            flags_in = flags_ff;
            if (pair_open)  flags_in.cloze = 1'b1;
            if (pair_close) flags_in.cloze = 1'b0;
         end else if (hold) begin
            flags_in = mid_flags;
         end else begin
            flags_in = fresh_res.flags;
         end
         held_valid_in = hold;
         held_char_in  = hold ? c : 8'h00;
         if (last) begin
            flags_in      = '0;
            held_valid_in = 1'b0;
            held_char_in  = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff      <= '0;
         held_char_ff  <= 8'h00;
         held_valid_ff <= 1'b0;
      end else begin
         flags_ff      <= flags_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // response transactions
   always_comb begin
      rsp0 = '0;
      rsp1 = '0;
      push_count = 2'd0;
      if (accept) begin
         if (keep_held && keep_fresh) begin
            rsp0.kept_byte    = held_char_ff;
            rsp0.byte_valid   = 1'b1;
            rsp1.kept_byte    = c;
            rsp1.byte_valid   = 1'b1;
            rsp1.end_of_text  = last;
            rsp1.last_of_item = 1'b1;
            push_count = 2'd2;
         end else if (keep_held || keep_fresh) begin
            rsp0.kept_byte    = keep_held ? held_char_ff : c;
            rsp0.byte_valid   = 1'b1;
            rsp0.end_of_text  = last;
            rsp0.last_of_item = 1'b1;
            push_count = 2'd1;
         end else if (last) begin
            rsp0.end_of_text  = 1'b1;
            rsp0.last_of_item = 1'b1;
            push_count = 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

/* src/msf_rsp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msf_rsp_queue: response queue
// takes up to two transactions per cycle and, while rsp_stall is low, delivers one per cycle
// ----------------------------------------------------------------------------
module msf_rsp_queue #(
   parameter int DEPTH = msf_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire msf_pkg::rsp_type push0,
   input  wire msf_pkg::rsp_type push1,
   input  wire logic [1:0]       push_count,
   output logic                  full,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output msf_pkg::rsp_type      rsp_data
);
   import msf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full      = count_ff > CW'(DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_next   = bump(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      case (push_count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = bump(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ptr_ff] <= push0;
      if (push_count == 2'd2) mem_ff[wr_next]   <= push1;
   end

endmodule
`default_nettype wire

/* src/markup_strip_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// markup_strip_filter: streaming markup stripper
// Request channel (req_valid/req_stall/req_data) carries one text byte per
// transaction, final_byte marking the last byte of a string. Tag, entity and
// cloze prefix text is dropped and brace pairs are removed; each request
// gives zero, one or two response transactions on rsp_valid/rsp_stall/
// rsp_data, and the last byte of a string always gives at least one, with
// end_of_text set on the final one.
// Responses are registered in the response queue before they are presented.
// Throughput: one request per cycle while req_stall is low; a request that
// keeps two bytes gives two response transactions, absorbed by the response queue.
// req_stall rises from the queue fill level alone, when fewer than two free
// entries remain, so a stalled receiver backs up into the request side after
// the queue fills.
// Reset clears the markup flags, the held pair byte and the queue.
// ----------------------------------------------------------------------------
module markup_strip_filter #(
   parameter int QUEUE_DEPTH = msf_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire msf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output msf_pkg::rsp_type      rsp_data
);
   import msf_pkg::*;

   logic       accept;
   rsp_type    rsp0, rsp1;
   logic [1:0] push_count;
   logic       full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   msf_step u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .rsp0       (rsp0),
      .rsp1       (rsp1),
      .push_count (push_count)
   );

   msf_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push0      (rsp0),
      .push1      (rsp1),
      .push_count (push_count),
      .full       (full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

/* tb/tb_markup_strip_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_markup_strip_filter: self-checking bench for the markup strip filter
// Strings of text bytes go in one transaction at a time. A scoreboard class
// predicts the kept bytes, the end-of-text marks and the per-request marks,
// and checks each response transaction in order. The strings are directed
// first, then random strings built from tags, entities, clozes with brace pairs,
// plain text and lone markup bytes, with some corrupted. Both sides idle at random, except in the final quiet stretch.
// ----------------------------------------------------------------------------
module tb_markup_strip_filter;
   import msf_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int TEXT_BYTES   = 500;
   localparam int QUIET_BYTES  = 80;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [7:0] MARKUP_CHARS [7] = '{CHAR_LT, CHAR_GT, CHAR_AMP, CHAR_SEMI,
                                               CHAR_LBR, CHAR_RBR, CHAR_COLON};

   class strip_scoreboard;
      logic       in_tag, cloze_on, in_entity, held_valid;
      logic [7:0] held_char;
      logic [7:0] kept_now[$];
      rsp_type    expected_kept[$];
      int         errors;
      int         checked;

      function new();
         clear_flags();
         errors  = 0;
         checked = 0;
      endfunction

      function void clear_flags();
         in_tag     = 1'b0;
         cloze_on   = 1'b0;
         in_entity  = 1'b0;
         held_valid = 1'b0;
         held_char  = 8'h00;
      endfunction

      // byte with no pair partner
      function void apply_single(logic [7:0] c);
         if (c == CHAR_LT) begin
            in_tag = 1'b1;
         end else if (c == CHAR_GT) begin
            in_tag = 1'b0;
         end else if (c == CHAR_AMP) begin
            in_entity = 1'b1;
         end else if (c == CHAR_SEMI) begin
            in_entity = 1'b0;
         end else if (!(in_tag || cloze_on || in_entity)) begin
            kept_now.push_back(c);
         end
      endfunction

      function void apply_fresh(logic [7:0] c, logic last);
         if ((c == CHAR_LBR || c == CHAR_RBR || (c == CHAR_COLON && cloze_on)) && !last) begin
            held_char  = c;
            held_valid = 1'b1;
         end else begin
            apply_single(c);
         end
      endfunction

      function void note_text_byte(req_type r);
         rsp_type    e;
         logic [7:0] h;
         kept_now.delete();
         if (held_valid) begin
            h          = held_char;
            held_valid = 1'b0;
            held_char  = 8'h00;
            if (h == CHAR_LBR && r.text_byte == CHAR_LBR) begin
               cloze_on = 1'b1;
            end else if (h == CHAR_COLON && r.text_byte == CHAR_COLON && cloze_on) begin
               cloze_on = 1'b0;
            end else if (!(h == CHAR_RBR && r.text_byte == CHAR_RBR)) begin
               apply_single(h);
               apply_fresh(r.text_byte, r.final_byte);
            end
         end else begin
            apply_fresh(r.text_byte, r.final_byte);
         end
         if (r.final_byte && kept_now.size() == 0) begin
            e              = '0;
            e.end_of_text  = 1'b1;
            e.last_of_item = 1'b1;
            expected_kept.push_back(e);
         end
         foreach (kept_now[i]) begin
            e              = '0;
            e.kept_byte    = kept_now[i];
            e.byte_valid   = 1'b1;
            e.last_of_item = (i == kept_now.size() - 1);
            e.end_of_text  = r.final_byte && (i == kept_now.size() - 1);
            expected_kept.push_back(e);
         end
         if (r.final_byte) begin
            clear_flags();
         end
      endfunction

      function void check_kept(rsp_type got);
         rsp_type e;
         if (expected_kept.size() == 0) begin
            $error("unexpected transaction, kept_byte %h", got.kept_byte);
            errors++;
            return;
         end
         e = expected_kept.pop_front();
         checked++;
         if (got.kept_byte !== e.kept_byte) begin
            $error("kept_byte: expected %h, actual %h", e.kept_byte, got.kept_byte);
            errors++;
         end
         if (got.byte_valid !== e.byte_valid) begin
            $error("byte_valid: expected %b, actual %b", e.byte_valid, got.byte_valid);
            errors++;
         end
         if (got.end_of_text !== e.end_of_text) begin
            $error("end_of_text: expected %b, actual %b", e.end_of_text, got.end_of_text);
            errors++;
         end
         if (got.last_of_item !== e.last_of_item) begin
            $error("last_of_item: expected %b, actual %b", e.last_of_item, got.last_of_item);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   strip_scoreboard strip;
   logic            idling_on;
   int              bytes_sent;
   int              strings_sent;
   int              cycle_count;

   markup_strip_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side stall bursts
   initial begin
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0 && idling_on && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 8);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         strip.check_kept(rsp_data);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_text(req_type r);
      int gap;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      strip.note_text_byte(r);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_bytes(logic [7:0] txt[$]);
      req_type r;
      foreach (txt[i]) begin
         r.text_byte  = txt[i];
         r.final_byte = (i == txt.size() - 1);
         send_text(r);
      end
      strings_sent++;
   endtask

   task automatic send_literal(string s);
      logic [7:0] txt[$];
      for (int i = 0; i < s.len(); i++) begin
         txt.push_back(s[i]);
      end
      send_bytes(txt);
   endtask

   function automatic void add_plain(ref logic [7:0] txt[$], input int lo, input int hi);
      int n;
      n = $urandom_range(lo, hi);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) begin
            txt.push_back(MARKUP_CHARS[$urandom_range(0, 6)]);
         end else begin
            txt.push_back(8'($urandom_range(1, 255)));
         end
      end
   endfunction

   task automatic send_random_string();
      logic [7:0] txt[$];
      int         pieces;
      pieces = $urandom_range(1, 4);
      repeat (pieces) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               txt.push_back(CHAR_LT);
               add_plain(txt, 0, 3);
               txt.push_back(CHAR_GT);
            end
            2: begin
               txt.push_back(CHAR_AMP);
               add_plain(txt, 0, 3);
               txt.push_back(CHAR_SEMI);
            end
            3, 4: begin
               txt.push_back(CHAR_LBR);
               txt.push_back(CHAR_LBR);
               add_plain(txt, 0, 3);
               txt.push_back(CHAR_COLON);
               txt.push_back(CHAR_COLON);
               add_plain(txt, 0, 3);
               txt.push_back(CHAR_RBR);
               txt.push_back(CHAR_RBR);
            end
            5: begin
               txt.push_back(MARKUP_CHARS[$urandom_range(0, 6)]);
            end
            default: begin
               add_plain(txt, 1, 4);
            end
         endcase
      end
      // broken markup
      if ($urandom_range(0, 4) == 0) begin
         txt[$urandom_range(0, txt.size() - 1)] = MARKUP_CHARS[$urandom_range(0, 6)];
      end
      send_bytes(txt);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      idling_on    = 1'b1;
      bytes_sent   = 0;
      strings_sent = 0;
      strip        = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_literal("a<b>c");
      send_literal("&a;");
      send_literal("{{q::w}}");
      send_literal(":x{");
      send_literal("}a");
      send_literal("<z");
      send_text('{text_byte: 8'hFF, final_byte: 1'b1});
      send_text('{text_byte: 8'h01, final_byte: 1'b1});

      while (bytes_sent < TEXT_BYTES) begin
         if (bytes_sent >= TEXT_BYTES - QUIET_BYTES) begin
            idling_on = 1'b0;
         end
         send_random_string();
      end
      req_valid <= 1'b0;

      while (strip.expected_kept.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("summary: %0d text bytes in %0d strings, %0d response transactions checked",
               bytes_sent, strings_sent, strip.checked);
      if (strip.errors == 0 && strip.expected_kept.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
src/msf_pkg.sv
src/msf_step.sv
src/msf_rsp_queue.sv
src/markup_strip_filter.sv
tb/tb_markup_strip_filter.sv
